// File: rtl/dkr_pkg.sv
package dkr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 12;
  localparam int FRAC_W   = 8;
  localparam int SCALE_W  = 3;
  localparam int MAX_SCALES = 8;
  localparam int NB_SIZE  = 27;
  localparam int CNT_W    = 5;
  localparam int MAC_STEPS = 39;
  localparam int STEP_W   = 6;
  localparam int DIV_STEPS = FRAC_W + 1;
  localparam logic [63:0] SINGULAR_LIMIT = 64'd281474977;

  // result status codes
  localparam logic [2:0] ST_KEPT     = 3'd0;
  localparam logic [2:0] ST_SCALE    = 3'd1;
  localparam logic [2:0] ST_SINGULAR = 3'd2;
  localparam logic [2:0] ST_LARGE    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;
  localparam logic [2:0] ST_CONTRAST = 3'd5;
  localparam logic [2:0] ST_EDGE     = 3'd6;

  // register indexes
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_SCOUNT   = 3'd2;
  localparam logic [2:0] REG_CONTRAST = 3'd3;
  localparam logic [2:0] REG_EDGE     = 3'd4;

  // MAC operand codes
  localparam logic [4:0] OP_H00 = 5'd0;
  localparam logic [4:0] OP_H11 = 5'd1;
  localparam logic [4:0] OP_H22 = 5'd2;
  localparam logic [4:0] OP_H01 = 5'd3;
  localparam logic [4:0] OP_H02 = 5'd4;
  localparam logic [4:0] OP_H12 = 5'd5;
  localparam logic [4:0] OP_G0  = 5'd6;
  localparam logic [4:0] OP_G1  = 5'd7;
  localparam logic [4:0] OP_G2  = 5'd8;
  localparam logic [4:0] OP_TR  = 5'd9;
  localparam logic [4:0] OP_LIM = 5'd10;
  localparam logic [4:0] OP_A00 = 5'd11;
  localparam logic [4:0] OP_A11 = 5'd12;
  localparam logic [4:0] OP_A22 = 5'd13;
  localparam logic [4:0] OP_A01 = 5'd14;
  localparam logic [4:0] OP_A02 = 5'd15;
  localparam logic [4:0] OP_A12 = 5'd16;

  // operand part: whole, low 21 bits unsigned, high part shifted by 21
  localparam logic [1:0] PT_FULL = 2'd0;
  localparam logic [1:0] PT_LO   = 2'd1;
  localparam logic [1:0] PT_HI   = 2'd2;
  localparam int SPLIT = 21;

  // accumulator destinations
  localparam logic [3:0] DS_NONE = 4'd0;
  localparam logic [3:0] DS_A00  = 4'd1;
  localparam logic [3:0] DS_A11  = 4'd2;
  localparam logic [3:0] DS_A22  = 4'd3;
  localparam logic [3:0] DS_A01  = 4'd4;
  localparam logic [3:0] DS_A02  = 4'd5;
  localparam logic [3:0] DS_A12  = 4'd6;
  localparam logic [3:0] DS_DET  = 4'd7;
  localparam logic [3:0] DS_N0   = 4'd8;
  localparam logic [3:0] DS_N1   = 4'd9;
  localparam logic [3:0] DS_N2   = 4'd10;
  localparam logic [3:0] DS_TR2  = 4'd11;
  localparam logic [3:0] DS_EP   = 4'd12;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic [1:0] part;
    logic       neg;
    logic       clr;
    logic [3:0] dst;
  } uop_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [3:0]  scount;
    logic [14:0] contrast;
    logic [15:0] edge_lim;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       calc;
    logic       mac_vld;
    uop_t       uop;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       out_load;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic scale_bad;
    logic singular;
    logic off_large;
    logic outside;
    logic low_contrast;
    logic edge_bad;
  } flags_t;

  function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic [1:0] p,
                              input logic neg, input logic clr, input logic [3:0] dst);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.part  = p;
    u.neg   = neg;
    u.clr   = clr;
    u.dst   = dst;
    return u;
  endfunction

  // adjugate, determinant, solve numerators and edge terms, one product per step
  function automatic uop_t mac_uop(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      6'd0:  u = mk(OP_H11, OP_H22, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd1:  u = mk(OP_H12, OP_H12, PT_FULL, 1'b1, 1'b0, DS_A00);
      6'd2:  u = mk(OP_H00, OP_H22, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd3:  u = mk(OP_H02, OP_H02, PT_FULL, 1'b1, 1'b0, DS_A11);
      6'd4:  u = mk(OP_H00, OP_H11, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd5:  u = mk(OP_H01, OP_H01, PT_FULL, 1'b1, 1'b0, DS_A22);
      6'd6:  u = mk(OP_H12, OP_H02, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd7:  u = mk(OP_H01, OP_H22, PT_FULL, 1'b1, 1'b0, DS_A01);
      6'd8:  u = mk(OP_H01, OP_H12, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd9:  u = mk(OP_H11, OP_H02, PT_FULL, 1'b1, 1'b0, DS_A02);
      6'd10: u = mk(OP_H02, OP_H01, PT_FULL, 1'b0, 1'b1, DS_NONE);
      6'd11: u = mk(OP_H12, OP_H00, PT_FULL, 1'b1, 1'b0, DS_A12);
      6'd12: u = mk(OP_H00, OP_A00, PT_LO,   1'b0, 1'b1, DS_NONE);
      6'd13: u = mk(OP_H00, OP_A00, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd14: u = mk(OP_H01, OP_A01, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd15: u = mk(OP_H01, OP_A01, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd16: u = mk(OP_H02, OP_A02, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd17: u = mk(OP_H02, OP_A02, PT_HI,   1'b0, 1'b0, DS_DET);
      6'd18: u = mk(OP_G0,  OP_A00, PT_LO,   1'b0, 1'b1, DS_NONE);
      6'd19: u = mk(OP_G0,  OP_A00, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd20: u = mk(OP_G1,  OP_A01, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd21: u = mk(OP_G1,  OP_A01, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd22: u = mk(OP_G2,  OP_A02, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd23: u = mk(OP_G2,  OP_A02, PT_HI,   1'b0, 1'b0, DS_N0);
      6'd24: u = mk(OP_G0,  OP_A01, PT_LO,   1'b0, 1'b1, DS_NONE);
      6'd25: u = mk(OP_G0,  OP_A01, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd26: u = mk(OP_G1,  OP_A11, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd27: u = mk(OP_G1,  OP_A11, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd28: u = mk(OP_G2,  OP_A12, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd29: u = mk(OP_G2,  OP_A12, PT_HI,   1'b0, 1'b0, DS_N1);
      6'd30: u = mk(OP_G0,  OP_A02, PT_LO,   1'b0, 1'b1, DS_NONE);
      6'd31: u = mk(OP_G0,  OP_A02, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd32: u = mk(OP_G1,  OP_A12, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd33: u = mk(OP_G1,  OP_A12, PT_HI,   1'b0, 1'b0, DS_NONE);
      6'd34: u = mk(OP_G2,  OP_A22, PT_LO,   1'b0, 1'b0, DS_NONE);
      6'd35: u = mk(OP_G2,  OP_A22, PT_HI,   1'b0, 1'b0, DS_N2);
      6'd36: u = mk(OP_TR,  OP_TR,  PT_FULL, 1'b0, 1'b1, DS_TR2);
      6'd37: u = mk(OP_LIM, OP_A22, PT_LO,   1'b0, 1'b1, DS_NONE);
      6'd38: u = mk(OP_LIM, OP_A22, PT_HI,   1'b0, 1'b0, DS_EP);
      default: u = mk(OP_H00, OP_H00, PT_FULL, 1'b0, 1'b1, DS_NONE);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/dog_keypoint_refine.sv
// Channel  | Direction | Handshake          | Payload
// in_*     | input     | in_valid/in_stall  | sample, key_x, key_y, key_scale, last
// out_*    | output    | out_valid/out_stall| status, refined_x/y/scale, centre_value
// cfg_*    | input     | APB write/read     | five 32-bit registers at 4*index
//
// Samples are taken one per cycle while the block collects a neighbourhood.
// After the last sample the solve runs the gradient/Hessian step, 39 passes through
// the shared multiply-accumulate, a drain and a check state, the divider (load,
// quotient steps, store for each of 3 offsets), a final check and the output load;
// rejects before the divide go straight to the output load. in_stall is high for
// the whole solve, longer while a result waits in the output register; once loaded,
// the next neighbourhood streams in while it waits. rst_n is synchronous, active low.
module dog_keypoint_refine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic [11:0]        in_key_x,
  input  logic [11:0]        in_key_y,
  input  logic [2:0]         in_key_scale,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [19:0]        out_refined_x,
  output logic [19:0]        out_refined_y,
  output logic [10:0]        out_refined_scale,
  output logic signed [15:0] out_centre_value,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  dkr_pkg::cfg_t   cfg;
  dkr_pkg::cmd_t   cmd;
  dkr_pkg::flags_t flags;

  dkr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  dkr_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .in_sample         (in_sample),
    .in_key_x          (in_key_x),
    .in_key_y          (in_key_y),
    .in_key_scale      (in_key_scale),
    .in_last           (in_last),
    .flags             (flags),
    .out_status        (out_status),
    .out_refined_x     (out_refined_x),
    .out_refined_y     (out_refined_y),
    .out_refined_scale (out_refined_scale),
    .out_centre_value  (out_centre_value)
  );

endmodule

// File: rtl/dkr_cfg.sv
module dkr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output dkr_pkg::cfg_t       cfg
);

  dkr_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx = cfg_paddr[4:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        dkr_pkg::REG_WIDTH:    cfg_nxt.width    = cfg_pwdata[12:0];
        dkr_pkg::REG_HEIGHT:   cfg_nxt.height   = cfg_pwdata[12:0];
        dkr_pkg::REG_SCOUNT:   cfg_nxt.scount   = cfg_pwdata[3:0];
        dkr_pkg::REG_CONTRAST: cfg_nxt.contrast = cfg_pwdata[14:0];
        dkr_pkg::REG_EDGE:     cfg_nxt.edge_lim = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dkr_pkg::REG_WIDTH:    cfg_prdata = {19'd0, cfg_r.width};
      dkr_pkg::REG_HEIGHT:   cfg_prdata = {19'd0, cfg_r.height};
      dkr_pkg::REG_SCOUNT:   cfg_prdata = {28'd0, cfg_r.scount};
      dkr_pkg::REG_CONTRAST: cfg_prdata = {17'd0, cfg_r.contrast};
      dkr_pkg::REG_EDGE:     cfg_prdata = {16'd0, cfg_r.edge_lim};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= 13'd640;
      cfg_r.height   <= 13'd480;
      cfg_r.scount   <= 4'd5;
      cfg_r.contrast <= 15'd492;
      cfg_r.edge_lim <= 16'd3098;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/dkr_dpath.sv
module dkr_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  dkr_pkg::cfg_t       cfg,
  input  dkr_pkg::cmd_t       cmd,
  input  logic signed [15:0]  in_sample,
  input  logic [11:0]         in_key_x,
  input  logic [11:0]         in_key_y,
  input  logic [2:0]          in_key_scale,
  input  logic                in_last,
  output dkr_pkg::flags_t     flags,
  output logic [2:0]          out_status,
  output logic [19:0]         out_refined_x,
  output logic [19:0]         out_refined_y,
  output logic [10:0]         out_refined_scale,
  output logic signed [15:0]  out_centre_value
);

  // neighbourhood and capture
  logic signed [15:0] nb_r [dkr_pkg::NB_SIZE];
  logic [4:0]  count_r, count_nxt, widx;
  logic [11:0] kx_r, ky_r;
  logic [2:0]  ks_r;

  assign widx = (count_r < 5'(dkr_pkg::NB_SIZE)) ? count_r : 5'(dkr_pkg::NB_SIZE - 1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.capture) begin
      if (in_last) count_nxt = 5'd0;
      else if (count_r < 5'(dkr_pkg::NB_SIZE)) count_nxt = count_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd0;
      kx_r    <= 12'd0;
      ky_r    <= 12'd0;
      ks_r    <= 3'd0;
    end else begin
      count_r <= count_nxt;
      if (cmd.capture && count_r == 5'd0) begin
        kx_r <= in_key_x;
        ky_r <= in_key_y;
        ks_r <= in_key_scale;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) nb_r[widx] <= in_sample;
  end

  // gradients (doubled) and Hessian (quadrupled)
  logic signed [19:0] h00_r, h11_r, h22_r;
  logic signed [17:0] h01_r, h02_r, h12_r;
  logic signed [16:0] g0_r, g1_r, g2_r;
  logic signed [20:0] tr_r;
  logic signed [19:0] h00_c, h11_c, h22_c, c2;

  assign c2    = 20'(nb_r[13]) <<< 1;
  assign h00_c = (20'(nb_r[14]) + 20'(nb_r[12]) - c2) <<< 2;
  assign h11_c = (20'(nb_r[16]) + 20'(nb_r[10]) - c2) <<< 2;
  assign h22_c = (20'(nb_r[22]) + 20'(nb_r[4])  - c2) <<< 2;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      h00_r <= h00_c;
      h11_r <= h11_c;
      h22_r <= h22_c;
      h01_r <= 18'(nb_r[17]) - 18'(nb_r[11]) - 18'(nb_r[15]) + 18'(nb_r[9]);
      h02_r <= 18'(nb_r[23]) - 18'(nb_r[5])  - 18'(nb_r[21]) + 18'(nb_r[3]);
      h12_r <= 18'(nb_r[25]) - 18'(nb_r[7])  - 18'(nb_r[19]) + 18'(nb_r[1]);
      g0_r  <= 17'(nb_r[14]) - 17'(nb_r[12]);
      g1_r  <= 17'(nb_r[16]) - 17'(nb_r[10]);
      g2_r  <= 17'(nb_r[22]) - 17'(nb_r[4]);
      tr_r  <= 21'(h00_c) + 21'(h11_c);
    end
  end

  // shared multiply-accumulate
  logic signed [41:0] a00_r, a11_r, a22_r, a01_r, a02_r, a12_r, tr2_r;
  logic signed [61:0] det_r;
  logic signed [59:0] n0_r, n1_r, n2_r;
  logic signed [57:0] ep_r;

  function automatic logic signed [63:0] opnd(input logic [4:0] code);
    logic signed [63:0] v;
    case (code)
      dkr_pkg::OP_H00: v = 64'(h00_r);
      dkr_pkg::OP_H11: v = 64'(h11_r);
      dkr_pkg::OP_H22: v = 64'(h22_r);
      dkr_pkg::OP_H01: v = 64'(h01_r);
      dkr_pkg::OP_H02: v = 64'(h02_r);
      dkr_pkg::OP_H12: v = 64'(h12_r);
      dkr_pkg::OP_G0:  v = 64'(g0_r);
      dkr_pkg::OP_G1:  v = 64'(g1_r);
      dkr_pkg::OP_G2:  v = 64'(g2_r);
      dkr_pkg::OP_TR:  v = 64'(tr_r);
      dkr_pkg::OP_LIM: v = $signed({48'd0, cfg.edge_lim});
      dkr_pkg::OP_A00: v = 64'(a00_r);
      dkr_pkg::OP_A11: v = 64'(a11_r);
      dkr_pkg::OP_A22: v = 64'(a22_r);
      dkr_pkg::OP_A01: v = 64'(a01_r);
      dkr_pkg::OP_A02: v = 64'(a02_r);
      dkr_pkg::OP_A12: v = 64'(a12_r);
      default:         v = 64'sd0;
    endcase
    return v;
  endfunction

  logic signed [63:0] opa, opb;
  logic signed [24:0] ma, mb;
  logic signed [49:0] prod, p_r;
  logic               pv_r, neg_r, clr_r, hi_r;
  logic [3:0]         dst_r;
  logic signed [63:0] ps, acc_r, acc_nxt;

  assign opa = opnd(cmd.uop.a_sel);
  assign opb = opnd(cmd.uop.b_sel);
  assign ma  = opa[24:0];

  always_comb begin
    unique case (cmd.uop.part)
      dkr_pkg::PT_LO: mb = $signed({4'd0, opb[dkr_pkg::SPLIT-1:0]});
      dkr_pkg::PT_HI: mb = opb[dkr_pkg::SPLIT+24:dkr_pkg::SPLIT];
      default:        mb = opb[24:0];
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mac_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= prod;
    neg_r <= cmd.uop.neg;
    clr_r <= cmd.uop.clr;
    dst_r <= cmd.uop.dst;
    hi_r  <= (cmd.uop.part == dkr_pkg::PT_HI);
  end

  assign ps      = hi_r ? (64'(p_r) <<< dkr_pkg::SPLIT) : 64'(p_r);
  assign acc_nxt = (clr_r ? 64'sd0 : acc_r) + (neg_r ? -ps : ps);

  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= acc_nxt;
      case (dst_r)
        dkr_pkg::DS_A00: a00_r <= acc_nxt[41:0];
        dkr_pkg::DS_A11: a11_r <= acc_nxt[41:0];
        dkr_pkg::DS_A22: a22_r <= acc_nxt[41:0];
        dkr_pkg::DS_A01: a01_r <= acc_nxt[41:0];
        dkr_pkg::DS_A02: a02_r <= acc_nxt[41:0];
        dkr_pkg::DS_A12: a12_r <= acc_nxt[41:0];
        dkr_pkg::DS_DET: det_r <= acc_nxt[61:0];
        dkr_pkg::DS_N0:  n0_r  <= acc_nxt[59:0];
        dkr_pkg::DS_N1:  n1_r  <= acc_nxt[59:0];
        dkr_pkg::DS_N2:  n2_r  <= acc_nxt[59:0];
        dkr_pkg::DS_TR2: tr2_r <= acc_nxt[41:0];
        dkr_pkg::DS_EP:  ep_r  <= acc_nxt[57:0];
        default: ;
      endcase
    end
  end

  // magnitudes and early rejects
  logic [61:0] adet;
  logic [59:0] m0, m1, m2;

  assign adet = det_r[61] ? 62'(-det_r) : 62'(det_r);
  assign m0   = n0_r[59] ? 60'(-n0_r) : 60'(n0_r);
  assign m1   = n1_r[59] ? 60'(-n1_r) : 60'(n1_r);
  assign m2   = n2_r[59] ? 60'(-n2_r) : 60'(n2_r);

  logic [3:0] cnt;
  assign cnt = (cfg.scount > 4'(dkr_pkg::MAX_SCALES)) ? 4'(dkr_pkg::MAX_SCALES) : cfg.scount;

  assign flags.scale_bad = (ks_r == 3'd0) || ({1'b0, ks_r} + 4'd1 >= cnt);
  assign flags.singular  = 64'(adet) < dkr_pkg::SINGULAR_LIMIT;
  assign flags.off_large = ({m0, 2'b00} >= adet) || ({m1, 2'b00} >= adet) ||
                           ({m2, 2'b00} >= adet);

  // restoring divider for the offset fraction
  logic signed [59:0] nsel;
  logic [59:0]        msel;
  logic [61:0]        rem_r;
  logic [62:0]        rem2;
  logic [8:0]         q_r;
  logic [9:0]         qr;
  logic signed [9:0]  off_c, off0_r, off1_r, off2_r;
  logic               oneg;

  always_comb begin
    unique case (cmd.div_sel)
      2'd1:    begin nsel = n1_r; msel = m1; end
      2'd2:    begin nsel = n2_r; msel = m2; end
      default: begin nsel = n0_r; msel = m0; end
    endcase
  end

  assign rem2  = {rem_r, 1'b0};
  assign qr    = 10'(({1'b0, q_r} + 10'd1) >> 1);
  assign oneg  = (nsel != 60'sd0) && (nsel[59] == det_r[61]);
  assign off_c = oneg ? -$signed(qr) : $signed(qr);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= {1'b0, msel, 1'b0};
      q_r   <= 9'd0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, adet}) begin
        rem_r <= 62'(rem2 - {1'b0, adet});
        q_r   <= {q_r[7:0], 1'b1};
      end else begin
        rem_r <= rem2[61:0];
        q_r   <= {q_r[7:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        2'd1:    off1_r <= off_c;
        2'd2:    off2_r <= off_c;
        default: off0_r <= off_c;
      endcase
    end
  end

  // refined position and late rejects
  logic signed [22:0] posx, posy, poss, limx, limy, lims;
  logic [16:0]        cmag;
  logic signed [63:0] tr2s, eps;

  assign posx = $signed({3'd0, kx_r, 8'd0}) + 23'(off0_r);
  assign posy = $signed({3'd0, ky_r, 8'd0}) + 23'(off1_r);
  assign poss = $signed({12'd0, ks_r, 8'd0}) + 23'(off2_r);
  assign limx = ($signed({10'd0, cfg.width})  - 23'sd1) <<< dkr_pkg::FRAC_W;
  assign limy = ($signed({10'd0, cfg.height}) - 23'sd1) <<< dkr_pkg::FRAC_W;
  assign lims = ($signed({19'd0, cnt}) - 23'sd1) <<< dkr_pkg::FRAC_W;

  assign flags.outside = posx[22] || (posx >= limx) || posy[22] || (posy >= limy) ||
                         poss[22] || (poss >= lims);

  assign cmag = nb_r[13][15] ? 17'(-17'(nb_r[13])) : 17'(nb_r[13]);
  assign flags.low_contrast = cmag < {2'b00, cfg.contrast};

  assign tr2s = 64'(tr2_r) <<< 8;
  assign eps  = 64'(ep_r);
  assign flags.edge_bad = (a22_r <= 42'sd0) || (tr2s >= eps);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= cmd.status;
      out_centre_value <= nb_r[13];
      if (cmd.status == dkr_pkg::ST_KEPT) begin
        out_refined_x     <= posx[19:0];
        out_refined_y     <= posy[19:0];
        out_refined_scale <= poss[10:0];
      end else begin
        out_refined_x     <= 20'd0;
        out_refined_y     <= 20'd0;
        out_refined_scale <= 11'd0;
      end
    end
  end

endmodule

// File: rtl/dkr_ctrl.sv
module dkr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  dkr_pkg::flags_t flags,
  output dkr_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_CALC    = 3'd1;
  localparam logic [2:0] S_MAC     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_CHECK   = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_FINAL   = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  localparam logic [3:0] DIV_LAST = 4'(dkr_pkg::DIV_STEPS + 1);

  logic [2:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [1:0] didx_r, didx_nxt;
  logic [3:0] dcnt_r, dcnt_nxt;
  logic [2:0] status_r, status_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_COLLECT);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    didx_nxt      = didx_r;
    dcnt_nxt      = dcnt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.uop       = dkr_pkg::mac_uop(step_r);
    cmd.div_sel   = didx_r;
    cmd.status    = status_r;
    unique case (state_r)
      S_COLLECT: begin
        cmd.capture = in_valid;
        if (in_valid && in_last) state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_vld = 1'b1;
        if (step_r == 6'(dkr_pkg::MAC_STEPS - 1)) state_nxt = S_DRAIN;
        else step_nxt = step_r + 6'd1;
      end
      S_DRAIN: state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (flags.scale_bad) begin
          status_nxt = dkr_pkg::ST_SCALE;
          state_nxt  = S_OUT;
        end else if (flags.singular) begin
          status_nxt = dkr_pkg::ST_SINGULAR;
          state_nxt  = S_OUT;
        end else if (flags.off_large) begin
          status_nxt = dkr_pkg::ST_LARGE;
          state_nxt  = S_OUT;
        end else begin
          didx_nxt  = 2'd0;
          dcnt_nxt  = 4'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // load, one quotient bit per cycle, then store the rounded offset
        if (dcnt_r == 4'd0) cmd.div_load = 1'b1;
        else if (dcnt_r == DIV_LAST) cmd.div_store = 1'b1;
        else cmd.div_step = 1'b1;
        if (dcnt_r == DIV_LAST) begin
          dcnt_nxt = 4'd0;
          if (didx_r == 2'd2) state_nxt = S_FINAL;
          else didx_nxt = didx_r + 2'd1;
        end else begin
          dcnt_nxt = dcnt_r + 4'd1;
        end
      end
      S_FINAL: begin
        priority if (flags.outside) status_nxt = dkr_pkg::ST_OUTSIDE;
        else if (flags.low_contrast) status_nxt = dkr_pkg::ST_CONTRAST;
        else if (flags.edge_bad) status_nxt = dkr_pkg::ST_EDGE;
        else status_nxt = dkr_pkg::ST_KEPT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_COLLECT;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      step_r      <= '0;
      didx_r      <= '0;
      dcnt_r      <= '0;
      status_r    <= dkr_pkg::ST_KEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      didx_r      <= didx_nxt;
      dcnt_r      <= dcnt_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> step_r < 6'(dkr_pkg::MAC_STEPS))
    else $error("MAC step out of range");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (dcnt_r <= DIV_LAST && didx_r != 2'd3))
    else $error("divider count out of range");

  a_mac_follows_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_CALC |-> (state_r == S_MAC && step_r == 6'd0))
    else $error("MAC program did not start at step zero");

endmodule

// File: dv/dog_keypoint_refine_tb.sv
`timescale 1ns / 1ps

module dog_keypoint_refine_tb;

  typedef struct {
    logic [2:0]         status;
    logic [19:0]        rx;
    logic [19:0]        ry;
    logic [10:0]        rs;
    logic signed [15:0] centre;
  } refine_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_sample;
  logic [11:0]        in_key_x;
  logic [11:0]        in_key_y;
  logic [2:0]         in_key_scale;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [19:0]        out_refined_x;
  logic [19:0]        out_refined_y;
  logic [10:0]        out_refined_scale;
  logic signed [15:0] out_centre_value;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [4:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  dog_keypoint_refine i_dut (.*);

  // predictor copy of the block state and registers
  logic signed [15:0] nb_store [27];
  int                 nb_count;
  int                 held_x, held_y, held_s;
  longint             reg_width, reg_height, reg_scount, reg_contrast, reg_edge;

  refine_res_t        pending_results[$];
  int                 error_count;
  int                 result_count;
  int                 item_count;
  int                 status_seen [7];
  int                 gap_pct;
  int                 stall_pct;
  logic signed [15:0] hood [27];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("dog_keypoint_refine_tb: FAIL");
    $finish;
  end

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int nidx(input int dx, input int dy, input int ds);
    return (ds + 1) * 9 + (dy + 1) * 3 + (dx + 1);
  endfunction

  function automatic refine_res_t refine_keypoint();
    refine_res_t r;
    longint w [27];
    longint h [3][3];
    longint adj [3][3];
    longint g [3];
    longint n [3];
    longint pos [3];
    longint lim [3];
    longint c, det, adet, cnt, d2, tr, num, rem, q;
    bit neg;
    r.status = dkr_pkg::ST_KEPT;
    r.rx = '0;
    r.ry = '0;
    r.rs = '0;
    r.centre = nb_store[13];
    cnt = reg_scount > dkr_pkg::MAX_SCALES ? dkr_pkg::MAX_SCALES : reg_scount;
    if (held_s <= 0 || held_s >= cnt - 1) begin
      r.status = dkr_pkg::ST_SCALE;
      return r;
    end
    foreach (w[i]) w[i] = nb_store[i];
    c = w[13];
    g[0] = w[nidx(1, 0, 0)] - w[nidx(-1, 0, 0)];
    g[1] = w[nidx(0, 1, 0)] - w[nidx(0, -1, 0)];
    g[2] = w[nidx(0, 0, 1)] - w[nidx(0, 0, -1)];
    h[0][0] = 4 * (w[nidx(1, 0, 0)] + w[nidx(-1, 0, 0)] - 2 * c);
    h[1][1] = 4 * (w[nidx(0, 1, 0)] + w[nidx(0, -1, 0)] - 2 * c);
    h[2][2] = 4 * (w[nidx(0, 0, 1)] + w[nidx(0, 0, -1)] - 2 * c);
    h[0][1] = w[nidx(1, 1, 0)] - w[nidx(1, -1, 0)] - w[nidx(-1, 1, 0)] + w[nidx(-1, -1, 0)];
    h[0][2] = w[nidx(1, 0, 1)] - w[nidx(1, 0, -1)] - w[nidx(-1, 0, 1)] + w[nidx(-1, 0, -1)];
    h[1][2] = w[nidx(0, 1, 1)] - w[nidx(0, 1, -1)] - w[nidx(0, -1, 1)] + w[nidx(0, -1, -1)];
    h[1][0] = h[0][1];
    h[2][0] = h[0][2];
    h[2][1] = h[1][2];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[j][i] = h[(i+1)%3][(j+1)%3] * h[(i+2)%3][(j+2)%3]
                  - h[(i+1)%3][(j+2)%3] * h[(i+2)%3][(j+1)%3];
    det = h[0][0] * adj[0][0] + h[0][1] * adj[1][0] + h[0][2] * adj[2][0];
    adet = mag(det);
    if (adet < longint'(dkr_pkg::SINGULAR_LIMIT)) begin
      r.status = dkr_pkg::ST_SINGULAR;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = adj[i][0] * g[0] + adj[i][1] * g[1] + adj[i][2] * g[2];
      if (4 * mag(n[i]) >= adet) begin
        r.status = dkr_pkg::ST_LARGE;
        return r;
      end
    end
    pos[0] = held_x * 256;
    pos[1] = held_y * 256;
    pos[2] = held_s * 256;
    for (int i = 0; i < 3; i++) begin
      // offset = -2 * adj * g / det, rounded half away from zero
      rem = 2 * mag(n[i]);
      q = 0;
      for (int k = 0; k <= dkr_pkg::FRAC_W; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= adet) begin
          rem -= adet;
          q |= 1;
        end
      end
      q = (q + 1) >> 1;
      neg = n[i] != 0 && ((n[i] < 0) == (det < 0));
      pos[i] += neg ? -q : q;
    end
    lim[0] = (reg_width - 1) * 256;
    lim[1] = (reg_height - 1) * 256;
    lim[2] = (cnt - 1) * 256;
    for (int i = 0; i < 3; i++)
      if (pos[i] < 0 || pos[i] >= lim[i]) begin
        r.status = dkr_pkg::ST_OUTSIDE;
        return r;
      end
    if (mag(c) < reg_contrast) begin
      r.status = dkr_pkg::ST_CONTRAST;
      return r;
    end
    d2 = h[0][0] * h[1][1] - h[0][1] * h[0][1];
    tr = h[0][0] + h[1][1];
    if (d2 <= 0 || tr * tr * 256 >= reg_edge * d2) begin
      r.status = dkr_pkg::ST_EDGE;
      return r;
    end
    r.rx = pos[0][19:0];
    r.ry = pos[1][19:0];
    r.rs = pos[2][10:0];
    return r;
  endfunction

  // update the predictor with one accepted sample request
  task automatic predict_sample();
    if (nb_count == 0) begin
      held_x = in_key_x;
      held_y = in_key_y;
      held_s = in_key_scale;
    end
    nb_store[nb_count < 27 ? nb_count : 26] = in_sample;
    if (nb_count < 27) nb_count++;
    item_count++;
    if (in_last) begin
      nb_count = 0;
      pending_results.push_back(refine_keypoint());
    end
  endtask

  always @(posedge clk) begin
    refine_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, out_status);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        status_seen[e.status]++;
        if (out_status !== e.status || out_refined_x !== e.rx || out_refined_y !== e.ry ||
            out_refined_scale !== e.rs || out_centre_value !== e.centre) begin
          $display("%0t: mismatch exp st=%0d x=%h y=%h s=%h c=%0d got st=%0d x=%h y=%h s=%h c=%0d",
                   $time, e.status, e.rx, e.ry, e.rs, e.centre, out_status, out_refined_x,
                   out_refined_y, out_refined_scale, out_centre_value);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_sample(input logic signed [15:0] s, input logic [11:0] kx,
                             input logic [11:0] ky, input logic [2:0] ks, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_key_x = kx;
    in_key_y = ky;
    in_key_scale = ks;
    in_last = last;
    do @(posedge clk); while (in_stall);
    predict_sample();
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
    in_last = 1'b0;
  endtask

  // send hood[] as a neighbourhood of cnt samples; cnt other than 27 marks last early or late
  task automatic send_hood(input int kx, input int ky, input int ks, input int cnt);
    bit scramble;
    scramble = $urandom_range(1);
    for (int k = 0; k < cnt; k++) begin
      if (k > 0 && scramble)
        send_sample(k < 27 ? hood[k] : 16'($urandom), 12'($urandom), 12'($urandom),
                    3'($urandom), k == cnt - 1);
      else
        send_sample(k < 27 ? hood[k] : 16'($urandom), 12'(kx), 12'(ky), 3'(ks), k == cnt - 1);
    end
  endtask

  // quadratic peak: centre c, curvatures a*, gradients g*, cross term, noise
  task automatic make_peak(input int c, input int ax, input int ay, input int as,
                           input int gx, input int gy, input int gs, input int cr,
                           input int noise);
    int v;
    for (int ds = -1; ds <= 1; ds++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          v = c - ax * dx * dx - ay * dy * dy - as * ds * ds + gx * dx + gy * dy + gs * ds
            + cr * dx * dy;
          if (noise > 0 && !(dx == 0 && dy == 0 && ds == 0))
            v += $urandom_range(2 * noise) - noise;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          hood[nidx(dx, dy, ds)] = 16'(v);
        end
  endtask

  task automatic make_noise();
    foreach (hood[i]) hood[i] = 16'($urandom);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("dog_keypoint_refine_tb: FAIL");
      $finish;
    end
    // let a block that is still solving a hood finish its solve
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = 5'(idx * 4);
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      dkr_pkg::REG_WIDTH:    reg_width = val & 32'h1fff;
      dkr_pkg::REG_HEIGHT:   reg_height = val & 32'h1fff;
      dkr_pkg::REG_SCOUNT:   reg_scount = val & 32'hf;
      dkr_pkg::REG_CONTRAST: reg_contrast = val & 32'h7fff;
      dkr_pkg::REG_EDGE:     reg_edge = val & 32'hffff;
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, input int h, input int sc, input int con,
                            input int edg);
    drain();
    cfg_write(dkr_pkg::REG_WIDTH, w);
    cfg_write(dkr_pkg::REG_HEIGHT, h);
    cfg_write(dkr_pkg::REG_SCOUNT, sc);
    cfg_write(dkr_pkg::REG_CONTRAST, con);
    cfg_write(dkr_pkg::REG_EDGE, edg);
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    // kept peak inside the image
    make_peak(9000, 1500, 1300, 1100, 200, -150, 100, 50, 0);
    send_hood(100, 50, 2, 27);
    // scale boundary at both ends
    send_hood(100, 50, 0, 27);
    send_hood(100, 50, 4, 27);
    // flat neighbourhood: singular Hessian
    foreach (hood[i]) hood[i] = 16'sd1000;
    send_hood(10, 10, 2, 27);
    // gradient too strong for the curvature
    make_peak(9000, 500, 500, 500, 4000, 0, 0, 0, 0);
    send_hood(10, 10, 2, 27);
    // negative offset at column zero
    make_peak(9000, 1500, 1500, 1500, -400, 0, 0, 0, 0);
    send_hood(0, 10, 2, 27);
    // low contrast
    make_peak(300, 60, 60, 60, 0, 0, 0, 0, 0);
    send_hood(10, 10, 2, 27);
    // ridge along one axis: edge response
    make_peak(9000, 3000, 20, 1000, 0, 0, 0, 0, 0);
    send_hood(10, 10, 2, 27);
    // extreme samples
    foreach (hood[i]) hood[i] = i[0] ? 16'sh7fff : 16'sh8000;
    send_hood(4095, 4095, 7, 27);
    // early last keeps the older entries, overlong hood overwrites the last one
    make_peak(-9000, -1500, -1400, -1200, 100, 100, -100, 0, 0);
    send_hood(200, 300, 2, 14);
    send_hood(200, 300, 2, 33);
    end_burst();
    drain();
    make_peak(9000, 1200, 1200, 1200, 0, 0, 0, 0, 30);
    send_hood(300, 200, 1, 27);
    end_burst();
  endtask

  task automatic test_random(input int hoods);
    int kind, cnt, ks, kx, ky, sgn, wl, hl;
    for (int n = 0; n < hoods; n++) begin
      case (n % 8)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        2: begin gap_pct = 62; stall_pct = 0;  end
        4: begin gap_pct = 0;  stall_pct = 62; end
        6: begin gap_pct = 34; stall_pct = 34; end
        default: ;
      endcase
      kind = $urandom_range(99);
      wl = reg_width > 4096 ? 4096 : (reg_width < 1 ? 1 : reg_width);
      hl = reg_height > 4096 ? 4096 : (reg_height < 1 ? 1 : reg_height);
      kx = $urandom_range(wl - 1);
      ky = $urandom_range(hl - 1);
      ks = $urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(2, 1);
      sgn = $urandom_range(1) ? 1 : -1;
      if (kind < 75)
        make_peak(sgn * $urandom_range(200, 20000), sgn * $urandom_range(100, 3000),
                  sgn * $urandom_range(100, 3000), sgn * $urandom_range(100, 3000),
                  $urandom_range(1200) - 600, $urandom_range(1200) - 600,
                  $urandom_range(1200) - 600, $urandom_range(400) - 200,
                  $urandom_range(3) == 0 ? $urandom_range(300) : 0);
      else
        make_noise();
      cnt = 27;
      if (kind >= 92) cnt = $urandom_range(1) ? $urandom_range(26, 1) : $urandom_range(40, 28);
      send_hood(kx, ky, ks, cnt);
    end
    end_burst();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_key_x = '0;
    in_key_y = '0;
    in_key_scale = '0;
    in_last = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    error_count = 0;
    result_count = 0;
    item_count = 0;
    nb_count = 0;
    held_x = 0;
    held_y = 0;
    held_s = 0;
    foreach (nb_store[i]) nb_store[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    reg_width = 640;
    reg_height = 480;
    reg_scount = 5;
    reg_contrast = 492;
    reg_edge = 3098;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(8);
    set_config(4096, 4096, 8, 0, 65535);
    test_random(7);
    set_config(1, 1, 1, 32767, 0);
    test_random(5);
    set_config(8191, 8191, 15, 100, 1000);
    test_random(7);
    set_config(300, 200, 4, 1000, 4000);
    test_random(7);
    set_config(0, 3000, 0, 200, 65535);
    test_random(5);
    set_config(2048, 2048, 6, 50, 2500);
    test_random(7);
    set_config(640, 480, 5, 492, 3098);
    test_random(7);

    drain();
    $display("run: %0d samples, %0d results; kept %0d scale %0d singular %0d large %0d",
             item_count, result_count, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    $display("     outside %0d contrast %0d edge %0d, over 8 register settings",
             status_seen[4], status_seen[5], status_seen[6]);
    if (error_count == 0)
      $display("dog_keypoint_refine_tb: PASS");
    else
      $display("dog_keypoint_refine_tb: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/dkr_pkg.sv
rtl/dkr_cfg.sv
rtl/dkr_dpath.sv
rtl/dkr_ctrl.sv
rtl/dog_keypoint_refine.sv
dv/dog_keypoint_refine_tb.sv
